/* rtl/crc_pkg.sv */
package crc_pkg;

  localparam int FUNC_W   = 2;
  localparam int FIELD_W  = 24;
  localparam int CHAR_W   = 8;
  localparam int SIZE_W   = 10;
  localparam int CELL_W   = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam int CX_LSB  = 0;
  localparam int CY_LSB  = 24;
  localparam int RAD_LSB = 48;
  localparam int PCH_LSB = 72;
  localparam int ROW_LSB = 80;
  localparam int COL_LSB = 89;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  localparam logic [SIZE_W-1:0] RESET_SIZE = 10'd1;
  localparam logic [CHAR_W-1:0] RESET_BG   = 8'd32;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DRAW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 2'd0,
    FN_FILL  = 2'd1,
    FN_RING  = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_R,
    ST_SQ_I,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROW,
    ST_COL,
    ST_RD,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctrl_t;

endpackage

/* rtl/crc_ram.sv */
module crc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  crc_pkg::ram_ctrl_t ctrl,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/circle_raster_canvas_unit.sv */
// A rejected draw, a clear or draw with no cells in use, and a read outside go straight to the result.
// The sweep steps one cell per cycle, painting hit cells through the canvas write port, with a
// row state before each row to restart the incremental squared-distance adder.
// Items are taken one at a time; the next one is accepted once the result is registered.
// Reset is synchronous and clears the controller, counters, configuration and result valid;
// canvas contents stay undefined until a clear writes them, and there is no clearing pass.
module circle_raster_canvas_unit #(
  parameter int MAX_SIDE  = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // center_x, center_y, radius, paint_char, cell_row, cell_col
  input  logic [crc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func
  input  logic [crc_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, cell_char
  output logic [crc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crc_pkg::SIZE_W-1:0]       cfg_data
);

  import crc_pkg::*;

  localparam int SIDE_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W   = SIDE_W + 1;
  localparam int EXT_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int ADDR_W  = 2 * SIDE_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int SPAN_W  = (FIELD_W > SIDE_W + FRAC_BITS + 1) ? FIELD_W
                                                               : SIDE_W + FRAC_BITS + 1;
  localparam int COORD_W = SPAN_W + 1;
  localparam int ACC_W   = 2 * COORD_W;
  localparam int SQ_W    = 2 * FIELD_W;

  localparam logic signed [FIELD_W-1:0] ONE    = FIELD_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0]   ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0]   STEP2  = ACC_W'(1) << (2 * FRAC_BITS + 1);
  localparam logic [EXT_W-1:0]          MAX_EXT = EXT_W'(MAX_SIDE);

  state_t state, state_next;

  logic [SIZE_W-1:0] cfg_w, cfg_h;
  logic [CHAR_W-1:0] bg;

  logic [EXT_W-1:0] w_ext, h_ext;
  logic [CNT_W-1:0] w_used, h_used;
  logic             no_cells;

  func_t                      in_func;
  logic signed [FIELD_W-1:0]  in_cx, in_cy, in_rad;
  logic [CHAR_W-1:0]          in_pch;
  logic [EXT_W-1:0]           in_row_ext, in_col_ext;
  logic                       in_bad_draw, in_outside;
  logic                       accept;

  func_t                      func;
  logic [CHAR_W-1:0]          pchar;
  logic signed [FIELD_W-1:0]  rad, inner, cx, cy;
  logic                       inner_neg;
  logic signed [ACC_W-1:0]    inc0x, incy, inc, d2, r2, inner2, cx2, dy2;
  logic [CNT_W-1:0]           col, row;
  logic                       last_col, last_row;
  logic [ADDR_W-1:0]          rd_addr;
  logic [STATUS_W-1:0]        res_status;
  logic [CHAR_W-1:0]          res_char;

  logic signed [FIELD_W-1:0]  mul_op;
  logic signed [SQ_W-1:0]     mul_sq;
  logic signed [ACC_W-1:0]    sq_ext;

  logic                       hit;
  logic                       load_out;
  ram_ctrl_t                  ram_ctrl;
  logic [CHAR_W-1:0]          ram_wdata;
  logic [CHAR_W-1:0]          ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= RESET_SIZE;
      cfg_h <= RESET_SIZE;
      bg    <= RESET_BG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg_w <= cfg_data;
        REG_HEIGHT: cfg_h <= cfg_data;
        REG_BG:     bg    <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes above the canvas capacity are clamped to it.
  assign w_ext    = EXT_W'(cfg_w);
  assign h_ext    = EXT_W'(cfg_h);
  assign w_used   = (w_ext > MAX_EXT) ? CNT_W'(MAX_EXT) : CNT_W'(w_ext);
  assign h_used   = (h_ext > MAX_EXT) ? CNT_W'(MAX_EXT) : CNT_W'(h_ext);
  assign no_cells = (w_used == '0) || (h_used == '0);

  assign in_func    = func_t'(s_axis_tuser);
  assign in_cx      = s_axis_tdata[CX_LSB +: FIELD_W];
  assign in_cy      = s_axis_tdata[CY_LSB +: FIELD_W];
  assign in_rad     = s_axis_tdata[RAD_LSB +: FIELD_W];
  assign in_pch     = s_axis_tdata[PCH_LSB +: CHAR_W];
  assign in_row_ext = EXT_W'(s_axis_tdata[ROW_LSB +: CELL_W]);
  assign in_col_ext = EXT_W'(s_axis_tdata[COL_LSB +: CELL_W]);
  assign in_bad_draw = in_rad[FIELD_W-1] || (in_rad == '0) || (in_pch == '0);
  assign in_outside  = (in_row_ext >= EXT_W'(h_used)) || (in_col_ext >= EXT_W'(w_used));
  assign accept      = s_axis_tvalid && s_axis_tready;

  assign last_col = (col == w_used - CNT_W'(1));
  assign last_row = (row == h_used - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func) inside
            FN_CLEAR: state_next = no_cells ? ST_DONE : ST_ROW;
            FN_FILL, FN_RING: state_next = (in_bad_draw || no_cells) ? ST_DONE : ST_SQ_R;
            FN_READ: state_next = in_outside ? ST_DONE : ST_RD;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SQ_R:    state_next = ST_SQ_I;
      ST_SQ_I:    state_next = ST_SQ_X;
      ST_SQ_X:    state_next = ST_SQ_Y;
      ST_SQ_Y:    state_next = ST_ROW;
      ST_ROW:     state_next = ST_COL;
      ST_COL: begin
        if (last_col) begin
          state_next = last_row ? ST_DONE : ST_ROW;
        end
      end
      ST_RD:      state_next = ST_RD_WAIT;
      ST_RD_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (func)
      FN_CLEAR: hit = 1'b1;
      FN_FILL:  hit = (d2 <= r2);
      FN_RING:  hit = (d2 < r2) && (inner_neg || (d2 > inner2));
      default:  hit = 1'b0;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !rst;
    cfg_ready     = (state == ST_IDLE) && !rst;
    ram_ctrl.we   = (state == ST_COL) && hit;
    ram_ctrl.re   = (state == ST_RD);
    load_out      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
    ram_wdata     = (func == FN_CLEAR) ? bg : pchar;
  end

  always_comb begin
    case (state)
      ST_SQ_R: mul_op = rad;
      ST_SQ_I: mul_op = inner;
      ST_SQ_X: mul_op = cx;
      default: mul_op = cy;
    endcase
  end

  assign mul_sq = mul_op * mul_op;
  assign sq_ext = ACC_W'(mul_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        row <= '0;
      end
      if (state == ST_ROW) begin
        col <= '0;
      end
      if (state == ST_COL) begin
        col <= col + CNT_W'(1);
        if (last_col) begin
          row <= row + CNT_W'(1);
        end
      end
    end
  end

  // Squared distances advance by first and second differences along rows and columns.
  always_ff @(posedge clk) begin
    if (accept) begin
      func      <= in_func;
      pchar     <= in_pch;
      rad       <= in_rad;
      inner     <= in_rad - ONE;
      inner_neg <= (in_rad < ONE);
      cx        <= in_cx;
      cy        <= in_cy;
      inc0x     <= ONE_SQ - (ACC_W'(in_cx) <<< (FRAC_BITS + 1));
      incy      <= ONE_SQ - (ACC_W'(in_cy) <<< (FRAC_BITS + 1));
      rd_addr   <= {in_row_ext[SIDE_W-1:0], in_col_ext[SIDE_W-1:0]};
      res_char  <= '0;
      case (in_func) inside
        FN_FILL, FN_RING: res_status <= in_bad_draw ? STATUS_BAD_DRAW : STATUS_OK;
        FN_READ:          res_status <= in_outside ? STATUS_OUTSIDE : STATUS_OK;
        default:          res_status <= STATUS_OK;
      endcase
    end
    case (state)
      ST_SQ_R: r2  <= sq_ext;
      ST_SQ_I: inner2 <= inner_neg ? '0 : sq_ext;
      ST_SQ_X: cx2 <= sq_ext;
      ST_SQ_Y: dy2 <= sq_ext;
      ST_ROW: begin
        d2   <= cx2 + dy2;
        inc  <= inc0x;
        dy2  <= dy2 + incy;
        incy <= incy + STEP2;
      end
      ST_COL: begin
        d2  <= d2 + inc;
        inc <= inc + STEP2;
      end
      ST_RD_WAIT: res_char <= ram_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= OUT_DATA_W'({res_char, res_status});
    end
  end

  crc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .ctrl  (ram_ctrl),
    .waddr ({row[SIDE_W-1:0], col[SIDE_W-1:0]}),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  a_write_in_canvas: assert property (@(posedge clk) disable iff (rst)
    ram_ctrl.we |-> (col < w_used) && (row < h_used))
    else $error("canvas write outside the cells in use");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] <= STATUS_OUTSIDE))
    else $error("result carries an undefined status code");

  a_read_issued: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_func == FN_READ) && !in_outside) |=> (state == ST_RD))
    else $error("in-range read did not start a canvas read");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the completion state");

endmodule
